### sv/lpq_pkg.sv
// Package: widths, register indexes, lamp codes and decode for the lever qualifier.
`timescale 1ns / 1ps
package lpq_pkg;

    localparam int HISTORY_DEPTH_DEF = 10;

    localparam int SAMPLE_W = 3;
    localparam int DUTY_W   = 8;
    localparam int MASK_W   = 5;
    localparam int COUNT_W  = 8;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DAY_MODE    = 2'd0,
        REG_DAY_DUTY    = 2'd1,
        REG_NIGHT_DUTY  = 2'd2,
        REG_ERROR_LIMIT = 2'd3
    } t_cfg_reg;

    localparam logic             DAY_MODE_RST    = 1'b1;
    localparam logic [DUTY_W-1:0] DAY_DUTY_RST    = 8'd200;
    localparam logic [DUTY_W-1:0] NIGHT_DUTY_RST  = 8'd40;
    localparam logic [COUNT_W-1:0] ERROR_LIMIT_RST = 8'd15;

    localparam logic [SAMPLE_W-1:0] PAT_P = 3'd4;
    localparam logic [SAMPLE_W-1:0] PAT_R = 3'd6;
    localparam logic [SAMPLE_W-1:0] PAT_N = 3'd7;
    localparam logic [SAMPLE_W-1:0] PAT_D = 3'd3;
    localparam logic [SAMPLE_W-1:0] PAT_M = 3'd1;

    localparam logic [MASK_W-1:0] LAMP_P    = 5'b01000;
    localparam logic [MASK_W-1:0] LAMP_R    = 5'b00001;
    localparam logic [MASK_W-1:0] LAMP_N    = 5'b00100;
    localparam logic [MASK_W-1:0] LAMP_D    = 5'b00010;
    localparam logic [MASK_W-1:0] LAMP_M    = 5'b10000;
    localparam logic [MASK_W-1:0] LAMP_NONE = 5'b00000;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_busy;
    } t_dp_sts;

    function automatic logic [MASK_W-1:0] decode_pattern(input logic [SAMPLE_W-1:0] pat);
        logic [MASK_W-1:0] m;
        case (pat)
            PAT_P:   m = LAMP_P;
            PAT_R:   m = LAMP_R;
            PAT_N:   m = LAMP_N;
            PAT_D:   m = LAMP_D;
            PAT_M:   m = LAMP_M;
            default: m = LAMP_NONE;
        endcase
        return m;
    endfunction

endpackage

### sv/lpq_if.sv
// Interfaces: sample input channel and lamp result channel.
`timescale 1ns / 1ps
interface lpq_in_if import lpq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] switch_sample;

    modport source (output valid, output switch_sample, input ready);
    modport sink   (input valid, input switch_sample, output ready);
endinterface

interface lpq_out_if import lpq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] lamp_duty;
    logic [MASK_W-1:0] lamp_mask;
    logic              fault;

    modport source (output valid, output lamp_duty, output lamp_mask, output fault,
                    input ready);
    modport sink   (input valid, input lamp_duty, input lamp_mask, input fault,
                    output ready);
endinterface

### sv/lpq_ctrl.sv
// Controller: accept, history scan and commit sequencing.
`timescale 1ns / 1ps
module lpq_ctrl import lpq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.commit = (r_state == S_COMMIT) && !i_sts.out_busy;
        n_state      = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_last) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/lpq_dp.sv
// Datapath: sample ring, compare scan, unsettled count, config and result register.
`timescale 1ns / 1ps
module lpq_dp import lpq_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [DUTY_W-1:0]    o_duty,
    output logic [MASK_W-1:0]    o_mask,
    output logic                 o_fault
);

    localparam int SW = $clog2(HISTORY_DEPTH);
    localparam logic [SW-1:0] SLOT_LAST = SW'(HISTORY_DEPTH - 1);

    logic [SAMPLE_W-1:0] r_hist [HISTORY_DEPTH];
    logic [SW-1:0]       r_slot;
    logic [SW-1:0]       r_idx;
    logic                r_diff;
    logic [COUNT_W-1:0]  r_cnt;
    logic [MASK_W-1:0]   r_mask;
    logic                r_fault;

    logic                r_day_mode;
    logic [DUTY_W-1:0]   r_day_duty;
    logic [DUTY_W-1:0]   r_night_duty;
    logic [COUNT_W-1:0]  r_limit;

    logic                r_out_valid;
    logic [DUTY_W-1:0]   r_out_duty;
    logic [MASK_W-1:0]   r_out_mask;
    logic                r_out_fault;

    logic [COUNT_W-1:0]  n_cnt;
    logic [MASK_W-1:0]   n_mask;
    logic                n_fault;
    logic [COUNT_W-1:0]  cnt_inc;
    logic [MASK_W-1:0]   settled_mask;

    assign o_sts.scan_last = (r_idx == SLOT_LAST);
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

    always_comb begin
        cnt_inc      = r_cnt + COUNT_W'(1);
        settled_mask = decode_pattern(r_hist[0]);
        n_cnt        = r_cnt;
        n_mask       = r_mask;
        n_fault      = r_fault;
        if (!r_diff) begin
            n_cnt   = '0;
            n_mask  = settled_mask;
            n_fault = (settled_mask == LAMP_NONE);
        end else if (cnt_inc >= r_limit) begin
            n_cnt   = cnt_inc - COUNT_W'(1);
            n_mask  = LAMP_NONE;
            n_fault = 1'b1;
        end else begin
            n_cnt   = cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HISTORY_DEPTH; k++) r_hist[k] <= '0;
            r_slot       <= '0;
            r_idx        <= '0;
            r_diff       <= 1'b0;
            r_cnt        <= '0;
            r_mask       <= LAMP_NONE;
            r_fault      <= 1'b0;
            r_day_mode   <= DAY_MODE_RST;
            r_day_duty   <= DAY_DUTY_RST;
            r_night_duty <= NIGHT_DUTY_RST;
            r_limit      <= ERROR_LIMIT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    REG_DAY_MODE:    r_day_mode   <= i_cfg_data[0];
                    REG_DAY_DUTY:    r_day_duty   <= i_cfg_data[DUTY_W-1:0];
                    REG_NIGHT_DUTY:  r_night_duty <= i_cfg_data[DUTY_W-1:0];
                    REG_ERROR_LIMIT: r_limit      <= i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_hist[r_slot] <= i_sample;
                r_slot <= (r_slot == SLOT_LAST) ? '0 : r_slot + SW'(1);
                r_idx  <= SW'(1);
                r_diff <= 1'b0;
            end
            if (i_cmd.scan) begin
                if (r_hist[r_idx] != r_hist[0]) r_diff <= 1'b1;
                if (r_idx != SLOT_LAST) r_idx <= r_idx + SW'(1);
            end
            if (i_cmd.commit) begin
                r_cnt       <= n_cnt;
                r_mask      <= n_mask;
                r_fault     <= n_fault;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_fault <= n_fault;
            r_out_mask  <= n_fault ? LAMP_NONE : n_mask;
            r_out_duty  <= n_fault ? '0 : (r_day_mode ? r_day_duty : r_night_duty);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_duty      = r_out_duty;
    assign o_mask      = r_out_mask;
    assign o_fault     = r_out_fault;

endmodule

### sv/lever_position_qualifier_core.sv
// Top level: lever position qualifier, controller plus datapath.
//
//  channel        dir  beat contents
//  i_sample_ch    in   switch_sample[2:0]
//  o_result_ch    out  lamp_duty[7:0], lamp_mask[4:0], fault
//  i_cfg_*        in   write enable, index[1:0], data[7:0]
//
// Each item passes through three steps in order: a write into the ring, an entry-by-entry
// compare of the ring against entry 0, and a commit. A new sample is accepted only in idle,
// once the previous item has committed; the compare uses a single port over the ring.
// Reset is synchronous; the ring, count, held mask and fault and the output valid clear, the beat fields do not.
// A stalled result beat holds the commit cycle until the output register frees up.
`timescale 1ns / 1ps
module lever_position_qualifier_core import lpq_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lpq_in_if.sink               i_sample_ch,
    lpq_out_if.source            o_result_ch,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    lpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample_ch.valid),
        .o_in_ready (i_sample_ch.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lpq_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_sample    (i_sample_ch.switch_sample),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (o_result_ch.ready),
        .o_out_valid (o_result_ch.valid),
        .o_duty      (o_result_ch.lamp_duty),
        .o_mask      (o_result_ch.lamp_mask),
        .o_fault     (o_result_ch.fault)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample_ch.valid && i_sample_ch.ready) |=> !i_sample_ch.ready)
        else $error("sample accepted while an item is in work");

    a_fault_blanks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_ch.valid && o_result_ch.fault) |->
        (o_result_ch.lamp_duty == '0 && o_result_ch.lamp_mask == LAMP_NONE))
        else $error("faulted beat drives lamps");

    a_mask_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_ch.valid |-> $onehot0(o_result_ch.lamp_mask))
        else $error("lamp mask not one-hot");

    a_commit_follows_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !i_sample_ch.ready)
        else $error("commit while idle");

endmodule
